>>> rtl/cbag_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// cbag_pkg
// Shared types and codes for the clipped blit address generator.
// ============================================================================
package cbag_pkg;

    localparam int BYTES_PER_PIXEL = 2;

    // Register stages between the config registers and the clip setup values
    localparam int SETUP_STAGES = 3;
    localparam int HOLD_W       = $clog2(SETUP_STAGES + 1);

    localparam int CFG_DATA_W = 13;

    // Input commands
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_BYTE  = 1'b1;

    // Result status codes
    localparam logic [2:0] STATUS_WRITTEN = 3'd0;
    localparam logic [2:0] STATUS_SKIPPED = 3'd1;
    localparam logic [2:0] STATUS_CULLED  = 3'd2;
    localparam logic [2:0] STATUS_STARTED = 3'd3;
    localparam logic [2:0] STATUS_IGNORED = 3'd4;

    typedef enum logic [2:0] {
        REG_POS_X         = 3'd0,
        REG_POS_Y         = 3'd1,
        REG_IMG_WIDTH     = 3'd2,
        REG_IMG_HEIGHT    = 3'd3,
        REG_MARGIN_LEFT   = 3'd4,
        REG_MARGIN_TOP    = 3'd5,
        REG_MARGIN_RIGHT  = 3'd6,
        REG_MARGIN_BOTTOM = 3'd7
    } cfg_index_t;

    typedef struct packed {
        logic       cmd;
        logic [7:0] pixel_byte;
    } cbag_in_t;

    typedef struct packed {
        logic        write_en;
        logic [19:0] fb_addr;
        logic [7:0]  fb_data;
        logic        done_res;
        logic [2:0]  status;
    } cbag_out_t;

endpackage

>>> rtl/clipped_blit_address_generator.sv
`timescale 1ns / 1ps
// ============================================================================
// clipped_blit_address_generator
// Clips an RGB565 image to the screen and maps each decoded image byte to
// a framebuffer byte address, or drops it when it lies in a cropped region.
// ============================================================================
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-----------------------------
//  in      | input     | in_valid / in_ready  | in_data  (cmd, pixel_byte)
//  out     | output    | out_valid / out_ready| out_data (write_en .. status)
//  cfg     | input     | cfg_we               | cfg_index, cfg_wdata
//
//  One item per cycle sustained while out_ready is high and the setup is
//  settled; each item passes the input register and the result register.
//  While a result waits, one more item is taken as long as the input
//  register is empty. The clip setup (crop widening, two multipliers, final
//  adds) is a 3-stage pipe fed by the config registers, so in_ready is low
//  during a config write, after reset and while the setup then settles.
//  Reset is asynchronous, active low, and leaves no image active.
//
module clipped_blit_address_generator #(
    parameter int SCREEN_WIDTH  = 800,
    parameter int SCREEN_HEIGHT = 480
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  cbag_pkg::cbag_in_t                 in_data,
    output logic                               out_valid,
    input  logic                               out_ready,
    output cbag_pkg::cbag_out_t                out_data,
    input  logic                               cfg_we,
    input  logic [2:0]                         cfg_index,
    input  logic [cbag_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
    import cbag_pkg::*;

    localparam logic signed [14:0] SW_S      = 15'(SCREEN_WIDTH);
    localparam logic signed [14:0] SH_S      = 15'(SCREEN_HEIGHT);
    localparam logic [19:0]        SW_20     = 20'(SCREEN_WIDTH);
    localparam logic [19:0]        ROW_PITCH = 20'(SCREEN_WIDTH * BYTES_PER_PIXEL);

    // ------------------------------------------------------------------
    // Config registers
    // ------------------------------------------------------------------
    logic [12:0] pos_x_reg, pos_y_reg;
    logic [11:0] img_width_reg, img_height_reg;
    logic [11:0] margin_left_reg, margin_top_reg, margin_right_reg, margin_bottom_reg;
    logic [HOLD_W-1:0] setup_hold_reg, setup_hold_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_x_reg         <= '0;
            pos_y_reg         <= '0;
            img_width_reg     <= '0;
            img_height_reg    <= '0;
            margin_left_reg   <= '0;
            margin_top_reg    <= '0;
            margin_right_reg  <= '0;
            margin_bottom_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                REG_POS_X:         pos_x_reg         <= cfg_wdata;
                REG_POS_Y:         pos_y_reg         <= cfg_wdata;
                REG_IMG_WIDTH:     img_width_reg     <= cfg_wdata[11:0];
                REG_IMG_HEIGHT:    img_height_reg    <= cfg_wdata[11:0];
                REG_MARGIN_LEFT:   margin_left_reg   <= cfg_wdata[11:0];
                REG_MARGIN_TOP:    margin_top_reg    <= cfg_wdata[11:0];
                REG_MARGIN_RIGHT:  margin_right_reg  <= cfg_wdata[11:0];
                REG_MARGIN_BOTTOM: margin_bottom_reg <= cfg_wdata[11:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        setup_hold_next = setup_hold_reg;
        if (cfg_we)
            setup_hold_next = HOLD_W'(SETUP_STAGES - 1);
        else if (setup_hold_reg != '0)
            setup_hold_next = setup_hold_reg - HOLD_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            setup_hold_reg <= HOLD_W'(SETUP_STAGES);
        else
            setup_hold_reg <= setup_hold_next;
    end

    // ------------------------------------------------------------------
    // Setup stage 1: widen crops so the image is clipped to the screen
    // ------------------------------------------------------------------
    logic signed [12:0] x_s, y_s;
    logic signed [14:0] x_end, y_end, x_over, y_over;
    logic [12:0] neg_x, neg_y;
    logic [12:0] cl_next, ct_next, cr_next, cb_next;
    logic [12:0] cl_reg, ct_reg, cr_reg, cb_reg;

    always_comb
    begin
        x_s    = $signed(pos_x_reg);
        y_s    = $signed(pos_y_reg);
        neg_x  = 13'(-x_s);
        neg_y  = 13'(-y_s);
        x_end  = 15'(x_s) + $signed({3'b000, img_width_reg});
        y_end  = 15'(y_s) + $signed({3'b000, img_height_reg});
        x_over = x_end - SW_S;
        y_over = y_end - SH_S;

        cl_next = {1'b0, margin_left_reg};
        if (x_s < 0 && neg_x > cl_next)
            cl_next = neg_x;
        ct_next = {1'b0, margin_top_reg};
        if (y_s < 0 && neg_y > ct_next)
            ct_next = neg_y;
        cr_next = {1'b0, margin_right_reg};
        if (x_end > SW_S && x_over[12:0] > cr_next)
            cr_next = x_over[12:0];
        cb_next = {1'b0, margin_bottom_reg};
        if (y_end > SH_S && y_over[12:0] > cb_next)
            cb_next = y_over[12:0];
    end

    // ------------------------------------------------------------------
    // Setup stage 2: cull test, row/column origin, products
    // ------------------------------------------------------------------
    logic [13:0] first_row, first_col;
    logic [13:0] crop_w_sum, crop_h_sum;
    logic [19:0] row_off_next;
    logic [24:0] ctw_next;
    logic [19:0] row_off_reg;
    logic [24:0] ctw_reg;
    logic [13:0] first_col_reg;
    logic [12:0] cl_d2_reg;
    logic        setup_cull_reg;
    logic [13:0] setup_row_bytes_reg, setup_row_gap_reg;
    logic [11:0] setup_rows_reg;

    always_comb
    begin
        first_row    = {pos_y_reg[12], pos_y_reg} + {1'b0, ct_reg};
        first_col    = {pos_x_reg[12], pos_x_reg} + {1'b0, cl_reg};
        crop_w_sum   = {1'b0, cl_reg} + {1'b0, cr_reg};
        crop_h_sum   = {1'b0, ct_reg} + {1'b0, cb_reg};
        // only the low 20 bits of the address survive
        row_off_next = {{6{first_row[13]}}, first_row} * SW_20;
        ctw_next     = {12'd0, ct_reg} * {13'd0, img_width_reg};
    end

    // ------------------------------------------------------------------
    // Setup stage 3: start address and initial skip count
    // ------------------------------------------------------------------
    logic [19:0] start_pix;
    logic [24:0] skip_pix;
    logic [19:0] setup_addr_reg;
    logic [24:0] setup_skip_reg;

    always_comb
    begin
        start_pix = row_off_reg + {{6{first_col_reg[13]}}, first_col_reg};
        skip_pix  = ctw_reg + {12'd0, cl_d2_reg};
    end

    always_ff @(posedge clk)
    begin
        cl_reg              <= cl_next;
        ct_reg              <= ct_next;
        cr_reg              <= cr_next;
        cb_reg              <= cb_next;
        row_off_reg         <= row_off_next;
        ctw_reg             <= ctw_next;
        first_col_reg       <= first_col;
        cl_d2_reg           <= cl_reg;
        setup_cull_reg      <= (crop_w_sum >= {2'b00, img_width_reg})
                            || (crop_h_sum >= {2'b00, img_height_reg});
        setup_row_bytes_reg <= {13'({1'b0, img_width_reg} - cl_reg - cr_reg), 1'b0};
        setup_row_gap_reg   <= {crop_w_sum[12:0], 1'b0};
        setup_rows_reg      <= img_height_reg - ct_reg[11:0] - cb_reg[11:0];
        setup_addr_reg      <= {start_pix[18:0], 1'b0};
        setup_skip_reg      <= {skip_pix[23:0], 1'b0};
    end

    // ------------------------------------------------------------------
    // Item path: input register -> per-byte logic -> result register
    // ------------------------------------------------------------------
    logic        item_valid_reg;
    cbag_in_t    item_reg;
    logic        out_valid_reg;
    cbag_out_t   out_data_reg;
    logic        advance, item_fire, accept;
    cbag_out_t   res;

    logic        active_reg, active_next;
    logic [24:0] skip_left_reg, skip_left_next;
    logic [13:0] copy_left_reg, copy_left_next, copy_dec;
    logic [11:0] rows_left_reg, rows_left_next, rows_dec;
    logic [19:0] write_ptr_reg, write_ptr_next;
    logic [19:0] row_start_ptr_reg, row_start_ptr_next, next_row_ptr;
    logic [13:0] row_bytes_reg, row_bytes_next;
    logic [13:0] row_gap_bytes_reg, row_gap_bytes_next;

    assign advance   = !out_valid_reg || out_ready;
    assign item_fire = item_valid_reg && advance;
    assign in_ready  = (!item_valid_reg || advance) && (setup_hold_reg == '0) && !cfg_we;
    assign accept    = in_valid && in_ready;

    always_comb
    begin
        active_next        = active_reg;
        skip_left_next     = skip_left_reg;
        copy_left_next     = copy_left_reg;
        rows_left_next     = rows_left_reg;
        write_ptr_next     = write_ptr_reg;
        row_start_ptr_next = row_start_ptr_reg;
        row_bytes_next     = row_bytes_reg;
        row_gap_bytes_next = row_gap_bytes_reg;
        copy_dec           = copy_left_reg - 14'd1;
        rows_dec           = rows_left_reg - 12'd1;
        next_row_ptr       = row_start_ptr_reg + ROW_PITCH;
        res                = '0;

        if (item_reg.cmd == CMD_START)
        begin
            if (setup_cull_reg)
            begin
                active_next = 1'b0;
                res.status  = STATUS_CULLED;
            end
            else
            begin
                active_next        = 1'b1;
                write_ptr_next     = setup_addr_reg;
                row_start_ptr_next = setup_addr_reg;
                skip_left_next     = setup_skip_reg;
                row_bytes_next     = setup_row_bytes_reg;
                row_gap_bytes_next = setup_row_gap_reg;
                copy_left_next     = setup_row_bytes_reg;
                rows_left_next     = setup_rows_reg;
                res.status         = STATUS_STARTED;
            end
        end
        else if (!active_reg)
        begin
            res.status = STATUS_IGNORED;
        end
        else if (skip_left_reg != '0)
        begin
            skip_left_next = skip_left_reg - 25'd1;
            res.status     = STATUS_SKIPPED;
        end
        else
        begin
            res.write_en   = 1'b1;
            res.fb_addr    = write_ptr_reg;
            res.fb_data    = item_reg.pixel_byte;
            res.status     = STATUS_WRITTEN;
            write_ptr_next = write_ptr_reg + 20'd1;
            copy_left_next = copy_dec;
            if (copy_dec == '0)
            begin
                rows_left_next = rows_dec;
                if (rows_dec == '0)
                begin
                    // last visible row finished
                    active_next  = 1'b0;
                    res.done_res = 1'b1;
                end
                else
                begin
                    row_start_ptr_next = next_row_ptr;
                    write_ptr_next     = next_row_ptr;
                    copy_left_next     = row_bytes_reg;
                    skip_left_next     = row_gap_bytes_reg;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg    <= 1'b0;
            out_valid_reg     <= 1'b0;
            active_reg        <= 1'b0;
            skip_left_reg     <= '0;
            copy_left_reg     <= '0;
            rows_left_reg     <= '0;
            write_ptr_reg     <= '0;
            row_start_ptr_reg <= '0;
            row_bytes_reg     <= '0;
            row_gap_bytes_reg <= '0;
        end
        else
        begin
            if (accept)
                item_valid_reg <= 1'b1;
            else if (advance)
                item_valid_reg <= 1'b0;
            if (advance)
                out_valid_reg <= item_valid_reg;
            if (item_fire)
            begin
                active_reg        <= active_next;
                skip_left_reg     <= skip_left_next;
                copy_left_reg     <= copy_left_next;
                rows_left_reg     <= rows_left_next;
                write_ptr_reg     <= write_ptr_next;
                row_start_ptr_reg <= row_start_ptr_next;
                row_bytes_reg     <= row_bytes_next;
                row_gap_bytes_reg <= row_gap_bytes_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            item_reg <= in_data;
        if (item_fire)
            out_data_reg <= res;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_hold_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (setup_hold_reg != '0) |-> !in_ready)
        else $error("item taken while clip setup is settling");

    a_idle_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_data.write_en) |->
            (out_data.fb_addr == '0 && out_data.fb_data == '0 && !out_data.done_res))
        else $error("result fields set without a write");

    a_done_implies_write: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.done_res) |-> out_data.write_en)
        else $error("done without a write");

    a_done_ends_image: assert property (@(posedge clk) disable iff (!rst_n)
        (item_fire && res.done_res) |=> !active_reg)
        else $error("image still active after last row");

    a_stalled_item_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid_reg && !advance) |=> item_valid_reg)
        else $error("item lost in input register during stall");

endmodule
